/* rtl/lzss_window_decoder_assert.svh */
// Assertion macros used by the decoder's port checker (lzwd_checker).
// Each macro expands to one labeled concurrent assertion, sampled on the
// rising clock edge and disabled while the active-low reset is asserted.
`ifndef LZSS_WINDOW_DECODER_ASSERT_SVH
`define LZSS_WINDOW_DECODER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LZWD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzss_window_decoder: assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define LZWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzss_window_decoder: assertion failed");

`endif

/* rtl/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the LZSS window decoder: window geometry,
// start pointer, token field masks and the layout of one output request.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    // History window geometry
    localparam int unsigned WIN_BYTES = 1024;
    localparam int unsigned WIN_AW    = $clog2(WIN_BYTES);
    localparam logic [WIN_AW-1:0] WP_START = WIN_AW'(958);

    // Fill count saturates at the window size (one bit wider than an address)
    localparam logic [WIN_AW:0] FILL_FULL = (WIN_AW+1)'(WIN_BYTES);

    // Token decode
    localparam logic [15:0] FLAG_RELOAD = 16'hFF00;
    localparam logic [7:0]  POS_HI_MASK = 8'hC0;
    localparam logic [7:0]  LEN_MASK    = 8'h3F;
    localparam logic [6:0]  LEN_BIAS    = 7'd3;

    // Valid byte counts of one output request
    localparam logic [1:0] BYTE_CNT_ONE = 2'd1;
    localparam logic [1:0] BYTE_CNT_TWO = 2'd2;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [1:0] byte_count;
        logic       run_last;
        logic       stream_done;
    } t_result;

endpackage

/* rtl/lzss_window_decoder.sv */
// ----------------------------------------------------------------------------
// lzss_window_decoder
// Byte-serial LZSS decompressor with a 1024-byte history window held in one
// synchronous RAM. Decoded bytes leave in pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) moves one compressed byte per request;
//   i_start_stream marks the first byte of a stream and loads the remaining
//   count from the out_size register (i_cfg_valid / o_cfg_ready, written
//   while idle). Output channel (o_valid / i_stall) moves one or two decoded
//   bytes per request; o_run_last tags the last request caused by one input
//   byte, o_stream_done the request holding the final byte of the stream.
//   A literal is accepted, then written to the window from the emit stage.
//   For a back-reference the copy engine reads one window byte per cycle,
//   while the emit stage is free or emitting, through the RAM's single read
//   port and writes it back from the emit stage, with same-address
//   forwarding. A decoded byte passes the emit stage, and the pair buffer
//   when it opens a pair, before its request is registered on o_valid.
//   The window is not swept on a stream start: a fill count marks which
//   entries were written since the start, others read as zero.
//   Reset empties all channels and the remaining count; out_size goes to 0.
//   When i_stall holds the output register, one byte in the pair buffer and
//   one in the emit stage may wait; then the copy engine halts and o_stall
//   stays high.
// ----------------------------------------------------------------------------
module lzss_window_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data,
    // compressed input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_start_stream,
    // decoded output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_first,
    output logic [7:0]  o_byte_second,
    output logic [1:0]  o_byte_count,
    output logic        o_run_last,
    output logic        o_stream_done
);

    localparam int unsigned AW = lzwd_pkg::WIN_AW;

    // Parse phases
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_TOK1 = 2'd1;
    localparam logic [1:0] PH_TOK2 = 2'd2;

    // Window RAM
    logic [7:0]    r_mem [0:lzwd_pkg::WIN_BYTES-1];
    logic [7:0]    r_rdata;

    // Decode state
    logic [23:0]   r_out_size;
    logic [23:0]   r_rem,      n_rem;
    logic [AW-1:0] r_wp,       n_wp;
    logic [AW:0]   r_fill,     n_fill;
    logic [15:0]   r_flags,    n_flags;
    logic [1:0]    r_phase,    n_phase;
    logic [7:0]    r_held,     n_held;

    // Copy engine
    logic [AW-1:0] r_raddr,    n_raddr;
    logic [6:0]    r_copy_cnt, n_copy_cnt;

    // Emit stage: one byte waiting to be written and paired
    logic          r_b_vld,    n_b_vld;
    logic          r_b_last,   n_b_last;
    logic          r_b_use_mem, n_b_use_mem;
    logic [7:0]    r_b_data,   n_b_data;

    // Pair buffer and output register
    logic          r_pair_vld, n_pair_vld;
    logic [7:0]    r_pair,     n_pair;
    logic          r_out_vld,  n_out_vld;
    lzwd_pkg::t_result r_out,  n_out;

    logic          in_acc;
    logic          out_free;
    logic          need_push;
    logic          emit;
    logic          rd_en;
    logic [7:0]    b_byte;
    logic [AW-1:0] rd_off;
    logic          rd_ok;
    logic          rd_fwd;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_b_vld || (r_copy_cnt != 7'd0);
    assign in_acc      = i_valid && !o_stall;

    assign out_free  = !r_out_vld || !i_stall;
    assign need_push = r_pair_vld || r_b_last;
    assign emit      = r_b_vld && (!need_push || out_free);
    assign b_byte    = r_b_use_mem ? r_rdata : r_b_data;

    // Copy read: window entry valid if written since stream start
    assign rd_en  = (r_copy_cnt != 7'd0) && (!r_b_vld || emit);
    assign rd_off = r_raddr - lzwd_pkg::WP_START;
    assign rd_ok  = {1'b0, rd_off} < r_fill;
    assign rd_fwd = emit && (r_raddr == r_wp);

    // Next-state logic
    always_comb begin
        logic [23:0] rem_e;
        logic [15:0] flags_e;
        logic [1:0]  phase_e;
        logic [15:0] f_shift;
        logic [6:0]  len;
        logic        take_tok;

        n_rem       = r_rem;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_flags     = r_flags;
        n_phase     = r_phase;
        n_held      = r_held;
        n_raddr     = r_raddr;
        n_copy_cnt  = r_copy_cnt;
        n_b_vld     = r_b_vld;
        n_b_last    = r_b_last;
        n_b_use_mem = r_b_use_mem;
        n_b_data    = r_b_data;
        n_pair_vld  = r_pair_vld;
        n_pair      = r_pair;
        n_out_vld   = r_out_vld;
        n_out       = r_out;

        rem_e    = r_rem;
        flags_e  = r_flags;
        phase_e  = r_phase;
        f_shift  = 16'd0;
        len      = 7'd0;
        take_tok = 1'b0;

        // Output register drains
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        // Emit: write window, advance pointer, pair up
        if (emit) begin
            n_b_vld = 1'b0;
            n_wp    = r_wp + 1'b1;
            if (r_fill != lzwd_pkg::FILL_FULL) begin
                n_fill = r_fill + 1'b1;
            end
            n_rem = r_rem - 24'd1;
            if (need_push) begin
                n_out_vld       = 1'b1;
                n_out.run_last  = r_b_last;
                n_out.stream_done = r_b_last && (r_rem == 24'd1);
                n_pair_vld      = 1'b0;
                if (r_pair_vld) begin
                    n_out.byte_first  = r_pair;
                    n_out.byte_second = b_byte;
                    n_out.byte_count  = lzwd_pkg::BYTE_CNT_TWO;
                end else begin
                    n_out.byte_first  = b_byte;
                    n_out.byte_second = 8'h00;
                    n_out.byte_count  = lzwd_pkg::BYTE_CNT_ONE;
                end
            end else begin
                n_pair_vld = 1'b1;
                n_pair     = b_byte;
            end
        end

        // Copy engine issues one window read
        if (rd_en) begin
            n_raddr     = r_raddr + 1'b1;
            n_copy_cnt  = r_copy_cnt - 7'd1;
            n_b_vld     = 1'b1;
            n_b_last    = (r_copy_cnt == 7'd1);
            n_b_use_mem = !rd_fwd && rd_ok;
            n_b_data    = rd_fwd ? b_byte : 8'h00;
        end

        // Input request: parse one compressed byte
        if (in_acc) begin
            if (i_start_stream) begin
                n_wp    = lzwd_pkg::WP_START;
                n_fill  = '0;
                n_flags = 16'd0;
                n_phase = PH_FLAG;
                n_held  = 8'h00;
                n_rem   = r_out_size;
                rem_e   = r_out_size;
                flags_e = 16'd0;
                phase_e = PH_FLAG;
            end
            if (rem_e != 24'd0) begin
                f_shift = {1'b0, flags_e[15:1]};
                priority if (phase_e == PH_FLAG) begin
                    if (!f_shift[8]) begin
                        n_flags = lzwd_pkg::FLAG_RELOAD | {8'h00, i_in_byte};
                        n_phase = PH_TOK1;
                    end else begin
                        n_flags  = f_shift;
                        flags_e  = f_shift;
                        take_tok = 1'b1;
                    end
                end else if (phase_e == PH_TOK1) begin
                    take_tok = 1'b1;
                end else begin
                    // Second back-reference byte: start the copy
                    len = {1'b0, i_in_byte[5:0] & lzwd_pkg::LEN_MASK[5:0]}
                          + lzwd_pkg::LEN_BIAS;
                    if ({17'd0, len} > rem_e) begin
                        len = rem_e[6:0];
                    end
                    n_raddr = {i_in_byte[7:6] & lzwd_pkg::POS_HI_MASK[7:6], r_held};
                    n_copy_cnt = len;
                    n_phase    = PH_FLAG;
                end
                if (take_tok) begin
                    if (flags_e[0]) begin
                        // Literal
                        n_b_vld     = 1'b1;
                        n_b_last    = 1'b1;
                        n_b_use_mem = 1'b0;
                        n_b_data    = i_in_byte;
                        n_phase     = PH_FLAG;
                    end else begin
                        n_held  = i_in_byte;
                        n_phase = PH_TOK2;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_size <= 24'd0;
            r_rem      <= 24'd0;
            r_wp       <= lzwd_pkg::WP_START;
            r_fill     <= '0;
            r_flags    <= 16'd0;
            r_phase    <= PH_FLAG;
            r_held     <= 8'h00;
            r_copy_cnt <= 7'd0;
            r_b_vld    <= 1'b0;
            r_pair_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_out_size <= i_cfg_data;
            end
            r_rem      <= n_rem;
            r_wp       <= n_wp;
            r_fill     <= n_fill;
            r_flags    <= n_flags;
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_copy_cnt <= n_copy_cnt;
            r_b_vld    <= n_b_vld;
            r_pair_vld <= n_pair_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_raddr     <= n_raddr;
        r_b_last    <= n_b_last;
        r_b_use_mem <= n_b_use_mem;
        r_b_data    <= n_b_data;
        r_pair      <= n_pair;
        r_out       <= n_out;
    end

    // Window RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_mem[r_wp] <= b_byte;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_byte_first  = r_out.byte_first;
    assign o_byte_second = r_out.byte_second;
    assign o_byte_count  = r_out.byte_count;
    assign o_run_last    = r_out.run_last;
    assign o_stream_done = r_out.stream_done;

endmodule

/* rtl/lzwd_checker.sv */
// ----------------------------------------------------------------------------
// lzwd_checker
// Port-level checks on the decoder's output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzss_window_decoder_assert.svh"

module lzwd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_byte_first,
    input logic [7:0] o_byte_second,
    input logic [1:0] o_byte_count,
    input logic       o_run_last,
    input logic       o_stream_done
);

    // A stalled request keeps its bytes, byte count and stream_done tag
    `LZWD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_byte_first) && $stable(o_byte_second) && $stable(o_byte_count) && $stable(o_stream_done))

    // Each request carries one or two bytes
    `LZWD_ASSERT_IMPLY(a_count_legal, i_clk, i_rst_n, o_valid, (o_byte_count == lzwd_pkg::BYTE_CNT_ONE) || (o_byte_count == lzwd_pkg::BYTE_CNT_TWO))

    // An unpaired byte leaves the second slot zero
    `LZWD_ASSERT_IMPLY(a_single_zero, i_clk, i_rst_n, o_valid && (o_byte_count == lzwd_pkg::BYTE_CNT_ONE), o_byte_second == 8'h00)

    // The final byte of a stream always closes a run
    `LZWD_ASSERT_IMPLY(a_done_is_last, i_clk, i_rst_n, o_valid && o_stream_done, o_run_last)

endmodule

bind lzss_window_decoder lzwd_checker u_lzwd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_byte_first  (o_byte_first),
    .o_byte_second (o_byte_second),
    .o_byte_count  (o_byte_count),
    .o_run_last    (o_run_last),
    .o_stream_done (o_stream_done)
);

/* tb/lzss_window_decoder_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decoder_checker
// Passive checker for the LZSS window decoder. It follows register writes and
// accepted input requests, decodes them with its own model of the window and
// the token parser, and compares each output request field by field against
// the oldest expectation.
// ----------------------------------------------------------------------------
module lzss_window_decoder_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [23:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_start_stream,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  lzwd_pkg::t_result i_result,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    localparam int AW = lzwd_pkg::WIN_AW;

    typedef enum logic [1:0] {
        PH_FLAG_OR_TOKEN,
        PH_TOKEN_FIRST,
        PH_REF_SECOND
    } t_parse;

    // decoder model state
    logic [7:0]        hist [lzwd_pkg::WIN_BYTES];
    logic [AW-1:0]     wr_ptr;
    logic [15:0]       flags;
    t_parse            parse;
    logic [7:0]        ref_lo;
    logic [23:0]       remaining;
    logic [23:0]       out_size;

    logic [7:0]        run_bytes [$];
    lzwd_pkg::t_result expected_q [$];
    int                fail_cnt = 0;
    int                checked_cnt = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_cnt++;
        $display("[%0t] mismatch on output request %0d: %s got 0x%0h, want 0x%0h",
                 $time, checked_cnt, what, got, want);
    endtask

    task automatic restart_window();
        int i;
        for (i = 0; i < lzwd_pkg::WIN_BYTES; i++)
            hist[i] = '0;
        wr_ptr = lzwd_pkg::WP_START;
        flags  = '0;
        parse  = PH_FLAG_OR_TOKEN;
        ref_lo = '0;
    endtask

    // one decoded byte: into the window and the current run
    task automatic put_decoded(input logic [7:0] b);
        hist[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        run_bytes = {run_bytes, b};
        if (remaining != 0)
            remaining = remaining - 1'b1;
    endtask

    // decode one compressed byte and queue the output requests it causes
    task automatic decode_request(input logic [7:0] b, input logic start);
        logic [15:0]       shifted;
        logic [AW-1:0]     src;
        int unsigned       len;
        int                i;
        int                nres;
        lzwd_pkg::t_result r;
        run_bytes.delete();
        if (start) begin
            restart_window();
            remaining = out_size;
        end
        // stream finished, never started or empty
        if (remaining == 0)
            return;

        if (parse == PH_FLAG_OR_TOKEN) begin
            shifted = flags >> 1;
            // marker bit gone: this byte is the next flag byte
            if (!shifted[8]) begin
                flags = lzwd_pkg::FLAG_RELOAD | {8'h00, b};
                parse = PH_TOKEN_FIRST;
                return;
            end
            flags = shifted;
            parse = PH_TOKEN_FIRST;
        end

        if (parse == PH_TOKEN_FIRST) begin
            if (flags[0]) begin
                put_decoded(b);
                parse = PH_FLAG_OR_TOKEN;
            end else begin
                ref_lo = b;
                parse  = PH_REF_SECOND;
                return;
            end
        end else begin
            // back-reference: absolute position, copy may overlap itself
            src = {b[7:6], ref_lo};
            len = 32'(b & lzwd_pkg::LEN_MASK) + 32'(lzwd_pkg::LEN_BIAS);
            if (len > remaining)
                len = 32'(remaining);
            for (i = 0; i < len; i++) begin
                put_decoded(hist[src]);
                src = src + 1'b1;
            end
            parse = PH_FLAG_OR_TOKEN;
        end

        // pack the run into pairs
        nres = (run_bytes.size() + 1) / 2;
        for (i = 0; i < nres; i++) begin
            r.byte_first = run_bytes[2*i];
            if (2*i + 1 < run_bytes.size()) begin
                r.byte_second = run_bytes[2*i + 1];
                r.byte_count  = lzwd_pkg::BYTE_CNT_TWO;
            end else begin
                r.byte_second = '0;
                r.byte_count  = lzwd_pkg::BYTE_CNT_ONE;
            end
            r.run_last    = (i == nres - 1);
            r.stream_done = r.run_last && (remaining == 0);
            expected_q = {expected_q, r};
        end
    endtask

    task automatic check_result(input lzwd_pkg::t_result got);
        lzwd_pkg::t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch("request with none expected", 32'(got), '0);
            return;
        end
        want = expected_q.pop_front();
        checked_cnt++;
        if (got.byte_first !== want.byte_first)
            report_mismatch("byte_first", 32'(got.byte_first), 32'(want.byte_first));
        if (got.byte_second !== want.byte_second)
            report_mismatch("byte_second", 32'(got.byte_second), 32'(want.byte_second));
        if (got.byte_count !== want.byte_count)
            report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
        if (got.run_last !== want.run_last)
            report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
        if (got.stream_done !== want.stream_done)
            report_mismatch("stream_done", 32'(got.stream_done), 32'(want.stream_done));
    endtask

    // compare before predicting, so a fresh expectation cannot hide a stray request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_window();
            remaining = '0;
            out_size  = '0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result(i_result);
            if (i_cfg_valid && i_cfg_ready)
                out_size = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                decode_request(i_in_byte, i_start_stream);
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_cnt;
        o_checked    <= checked_cnt;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the LZSS window decoder. A short directed part covers flag,
// literal and back-reference tokens, overlapping and truncated copies, empty
// and finished streams and restarts inside a token; random well-formed
// streams with some broken ones follow under three stall mixes. The checker
// beside the block predicts and compares every output request.
// ----------------------------------------------------------------------------
module tb;

    localparam int          AW            = lzwd_pkg::WIN_AW;
    localparam int          LIMIT_CYCLES  = 500000;
    localparam int          RANDOM_ITEMS  = 460;
    localparam int          QUIET_CYCLES  = 8;
    localparam int          SETTLE_CYCLES = 80;
    localparam logic [23:0] SIZE_MAX      = 24'hFF_FFFF;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte      = '0;
    logic        start_stream = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [1:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    lzwd_pkg::t_result dut_result;

    int          fail_count;
    int          pending;
    int          checked;

    // stimulus bookkeeping
    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int unsigned cycles        = 0;
    int          live_items    = 0;
    int          sent_items    = 0;
    int          streams       = 0;
    logic [23:0] cur_size      = '0;
    int unsigned left          = 0;
    int unsigned written       = 0;
    logic [AW-1:0] wr_pos      = lzwd_pkg::WP_START;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    lzss_window_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_in_byte      (in_byte),
        .i_start_stream (start_stream),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_byte_first   (byte_first),
        .o_byte_second  (byte_second),
        .o_byte_count   (byte_count),
        .o_run_last     (run_last),
        .o_stream_done  (stream_done)
    );

    assign dut_result = {byte_first, byte_second, byte_count, run_last, stream_done};

    lzss_window_decoder_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_start_stream (start_stream),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result       (dut_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d output requests still expected",
                     cycles, pending);
            $display("** lzss_window_decoder: FAILED **");
            $finish;
        end
    end

    // one compressed byte; valid stays up after acceptance for the caller to decide
    task automatic push_byte(input logic [7:0] b, input logic start);
        logic taken;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        start_stream <= start;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        sent_items++;
        if (start) begin
            left    = cur_size;
            written = 0;
            wr_pos  = lzwd_pkg::WP_START;
            streams++;
        end
        if (left > 0)
            live_items++;
    endtask

    // track decoded bytes so the stream is ended where the block ends it
    function automatic void consume(input int unsigned n);
        int unsigned k;
        k = (n > left) ? left : n;
        left    = left - k;
        written = written + k;
        wr_pos  = wr_pos + k[AW-1:0];
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_out_size(input logic [23:0] value);
        logic taken;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_size = value;
    endtask

    task automatic directed_checks();
        // nothing started yet, then a stream with a size of zero
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        write_out_size(SIZE_MAX);
        // literal, longest copy overlapping its own output from 958, literals
        push_byte(8'hFD, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hBE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        // restart while busy: shortest copies from both ends of a cleared window
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hC0, 1'b0);
        push_byte(8'h12, 1'b0);
        // restart inside a token, copy cut at the end of the stream, then ignored
        write_out_size(24'd5);
        push_byte(8'hF9, 1'b1);
        push_byte(8'h11, 1'b0);
        push_byte(8'hBE, 1'b0);
        push_byte(8'hC2, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b0);
        write_out_size('0);
        push_byte(8'h5A, 1'b1);
        push_byte(8'hA5, 1'b0);
    endtask

    // one well-formed stream with random content, sometimes cut inside a token
    task automatic random_stream(input logic [23:0] size, input bit new_size,
                                 input int budget);
        logic [7:0]  flag;
        logic [5:0]  len_code;
        logic [AW-1:0] src;
        int unsigned back_dist;
        int unsigned span;
        int          j;
        bit          cut;
        if (new_size)
            write_out_size(size);
        cut  = 1'b0;
        flag = 8'($urandom);
        push_byte(flag, 1'b1);
        while (left > 0 && budget > 0 && !cut) begin
            for (j = 0; j < 8 && left > 0 && budget > 0 && !cut; j++) begin
                if (flag[j]) begin
                    push_byte(8'($urandom), 1'b0);
                    consume(1);
                    budget--;
                end else begin
                    case ($urandom_range(9))
                        0, 1:    len_code = 6'h3F;
                        2, 3:    len_code = 6'($urandom);
                        default: len_code = 6'($urandom_range(15));
                    endcase
                    // mostly recent history, near enough to overlap the copy
                    if (written > 0 && $urandom_range(9) < 7) begin
                        span = (written < lzwd_pkg::WIN_BYTES - 1) ? written
                                                                   : lzwd_pkg::WIN_BYTES - 1;
                        if ($urandom_range(1) == 0 && span > 8)
                            span = 8;
                        back_dist = $urandom_range(span, 1);
                        src  = wr_pos - back_dist[AW-1:0];
                    end else begin
                        src = AW'($urandom);
                    end
                    push_byte(src[7:0], 1'b0);
                    budget--;
                    if ($urandom_range(29) == 0) begin
                        cut = 1'b1;
                    end else begin
                        push_byte({src[9:8], len_code}, 1'b0);
                        consume(32'(len_code) + 32'd3);
                        budget--;
                    end
                end
            end
            if (left > 0 && budget > 0 && !cut) begin
                flag = 8'($urandom);
                push_byte(flag, 1'b0);
            end
        end
        // trailing bytes after the end are dropped by the block
        if (left == 0 && $urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) push_byte(8'($urandom), 1'b0);
    endtask

    task automatic run_random(input int target);
        logic [23:0] size;
        int          budget;
        bit          first;
        first = 1'b1;
        while (live_items < target) begin
            budget = 40;
            case ($urandom_range(19))
                0:       size = '0;
                1:       size = SIZE_MAX;
                2:       size = 24'($urandom);
                3:       size = 24'($urandom_range(3, 1));
                4: begin
                    size   = 24'($urandom_range(1500, 1100));
                    budget = 150;
                end
                default: size = 24'($urandom_range(160, 1));
            endcase
            random_stream(size, first || $urandom_range(3) != 0, budget);
            first = 1'b0;
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver often stalling
        in_idle_pct   = 6;
        out_stall_pct = 63;
        directed_checks();
        live_items = 0;
        run_random(RANDOM_ITEMS / 3);

        // sender often idle, receiver mostly ready
        in_idle_pct   = 63;
        out_stall_pct = 6;
        run_random(2 * RANDOM_ITEMS / 3);

        // full rate both sides
        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random(RANDOM_ITEMS);

        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("covered %0d compressed bytes (%0d inside live streams) in %0d streams",
                 sent_items, live_items, streams);
        $display("checked %0d output requests under three stall mixes, %0d mismatches",
                 checked, fail_count);
        if (fail_count == 0)
            $display("** lzss_window_decoder: PASSED **");
        else
            $display("** lzss_window_decoder: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lzwd_pkg.sv
rtl/lzss_window_decoder.sv
rtl/lzwd_checker.sv
tb/lzss_window_decoder_checker.sv
tb/tb.sv
